// ----- sv/scba_pkg.sv -----
// Package with constants and status codes of the slot allocator.
package scba_pkg;
    localparam int LIST_DEPTH_DEF    = 64;
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int SLOT_ID_BITS_DEF  = 10;
    localparam int KEY_BITS_DEF      = 32;
    localparam int XL                = 4;
    localparam int NUM_CLASSES       = XL + 1;

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_STORE    = 2'd1;
    localparam logic [1:0] OP_RETRIEVE = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_FIT     = 3'd1;
    localparam logic [2:0] ST_UNKNOWN    = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL = 3'd3;
    localparam logic [2:0] ST_LIST_FULL  = 3'd4;

    typedef logic [2:0] t_class;
endpackage

// ----- sv/size_class_best_fit_slot_allocator_unit.sv -----
// Size-class best-fit slot allocator: five FIFO free lists and a key table.
// Sequence: add goes from S_FIT to S_OUT; retrieve runs S_SCAN, S_RD, S_RET, S_OUT; store walks
// up past empty classes in S_FIT, then runs S_SCAN, S_RD, S_POP, S_OUT. The scan reads one table
// entry a cycle.
// Throughput: one item at a time; busy falls in the strobe cycle, so the next item can be
// accepted at the edge that ends it. Reset (synchronous, active low) empties all lists and
// invalidates all entries. The result is shown for one cycle with o_done; no stall exists.
module size_class_best_fit_slot_allocator_unit
    import scba_pkg::*;
#(
    parameter int LIST_DEPTH    = LIST_DEPTH_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int SLOT_ID_BITS  = SLOT_ID_BITS_DEF,
    parameter int KEY_BITS      = KEY_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_operation,
    input  logic [2:0]              i_size_class,
    input  logic [SLOT_ID_BITS-1:0] i_slot_id,
    input  logic [KEY_BITS-1:0]     i_item_key,
    output logic                    o_done,
    output logic [2:0]              o_status,
    output logic [SLOT_ID_BITS-1:0] o_granted_slot,
    output logic [2:0]              o_granted_class
);
    localparam int LB  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CB  = $clog2(LIST_DEPTH + 1);
    localparam int TB  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TCB = $clog2(TABLE_ENTRIES + 1);
    localparam int MB  = $clog2(NUM_CLASSES * LIST_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIT  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_POP  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_RET  = 3'd6;

    // Free-list and table storage.
    logic [SLOT_ID_BITS-1:0] r_fl_mem [NUM_CLASSES*LIST_DEPTH];
    logic [KEY_BITS-1:0]     r_key_mem [TABLE_ENTRIES];
    logic [SLOT_ID_BITS-1:0] r_eslot_mem [TABLE_ENTRIES];
    t_class                  r_eclass_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [LB-1:0] r_head [NUM_CLASSES];
    logic [LB-1:0] r_tail [NUM_CLASSES];
    logic [CB-1:0] r_cnt  [NUM_CLASSES];

    logic [2:0]              r_state;
    logic [1:0]              r_op;
    t_class                  r_cls;
    logic [SLOT_ID_BITS-1:0] r_slot;
    logic [KEY_BITS-1:0]     r_key;
    logic [TCB-1:0]          r_idx;
    logic                    r_hit, r_free_ok;
    logic [TB-1:0]           r_hit_idx, r_free_idx;
    logic [KEY_BITS-1:0]     r_rd_key;
    logic [SLOT_ID_BITS-1:0] r_rd_slot, r_fl_rd;
    t_class                  r_rd_class;
    logic                    r_done;
    logic [2:0]              r_status;
    logic [SLOT_ID_BITS-1:0] r_gslot;
    t_class                  r_gclass;

    logic [MB-1:0] n_push_addr;
    logic [MB-1:0] n_pop_addr;
    logic          n_rd_valid;

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_granted_slot  = r_gslot;
    assign o_granted_class = r_gclass;

    // Flat free-list addresses for push at the tail and pop at the head.
    always_comb begin
        n_push_addr = MB'(r_cls * LIST_DEPTH) + MB'(r_tail[r_cls[2:0] > 3'(XL) ? 3'd0 : r_cls]);
        n_pop_addr  = MB'(r_cls * LIST_DEPTH) + MB'(r_head[r_cls[2:0] > 3'(XL) ? 3'd0 : r_cls]);
        n_rd_valid  = r_valid[r_idx[TB-1:0]];
    end

    // Registered reads: table key, one entry per cycle during the scan; entry slot, class and list head.
    always_ff @(posedge i_clk) begin
        r_rd_key   <= r_key_mem[r_idx[TB-1:0]];
        r_rd_slot  <= r_eslot_mem[r_hit_idx];
        r_rd_class <= r_eclass_mem[r_hit_idx];
        r_fl_rd    <= r_fl_mem[n_pop_addr];
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c] <= '0;
                r_tail[c] <= '0;
                r_cnt[c]  <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op      <= i_operation;
                        r_cls     <= i_size_class;
                        r_slot    <= i_slot_id;
                        r_key     <= i_item_key;
                        r_idx     <= '0;
                        r_hit     <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_status  <= ST_OK;
                        r_gslot   <= '0;
                        r_gclass  <= '0;
                        priority case (i_operation)
                            OP_ADD:      r_state <= S_FIT;
                            OP_STORE:    r_state <= S_FIT;
                            OP_RETRIEVE: r_state <= S_SCAN;
                            default:     r_state <= S_OUT;
                        endcase
                    end
                end
                S_FIT: begin
                    // Add pushes here; store walks up one class per cycle.
                    if (r_op == OP_ADD) begin
                        if (r_cls > 3'(XL) || r_cnt[r_cls] >= CB'(LIST_DEPTH)) begin
                            r_status <= ST_LIST_FULL;
                        end else begin
                            r_fl_mem[n_push_addr] <= r_slot;
                            r_tail[r_cls] <= (r_tail[r_cls] == LB'(LIST_DEPTH - 1)) ?
                                             '0 : r_tail[r_cls] + 1'b1;
                            r_cnt[r_cls] <= r_cnt[r_cls] + 1'b1;
                        end
                        r_state <= S_OUT;
                    end else if (r_cls > 3'(XL)) begin
                        r_status <= ST_NO_FIT;
                        r_state  <= S_OUT;
                    end else if (r_cnt[r_cls] != '0) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_cls <= r_cls + 1'b1;
                    end
                end
                S_SCAN: begin
                    // Key read data is registered, so it arrives in the cycle after its index.
                    r_idx <= r_idx + 1'b1;
                    if (r_idx != '0) begin
                        if (r_valid[TB'(r_idx - 1'b1)] && r_rd_key == r_key && !r_hit) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= TB'(r_idx - 1'b1);
                        end
                    end
                    if (r_idx < TCB'(TABLE_ENTRIES) && !n_rd_valid && !r_free_ok) begin
                        r_free_ok  <= 1'b1;
                        r_free_idx <= r_idx[TB-1:0];
                    end
                    if (r_idx == TCB'(TABLE_ENTRIES)) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // Entry fields and list head are read this cycle.
                    if (r_op == OP_STORE) begin
                        if (!r_hit && !r_free_ok) begin
                            r_status <= ST_TABLE_FULL;
                            r_state  <= S_OUT;
                        end else begin
                            if (!r_hit) r_hit_idx <= r_free_idx;
                            r_state <= S_POP;
                        end
                    end else if (!r_hit) begin
                        r_status <= ST_UNKNOWN;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_RET;
                    end
                end
                S_POP: begin
                    r_valid[r_hit_idx]      <= 1'b1;
                    r_key_mem[r_hit_idx]    <= r_key;
                    r_eslot_mem[r_hit_idx]  <= r_fl_rd;
                    r_eclass_mem[r_hit_idx] <= r_cls;
                    r_head[r_cls] <= (r_head[r_cls] == LB'(LIST_DEPTH - 1)) ?
                                     '0 : r_head[r_cls] + 1'b1;
                    r_cnt[r_cls] <= r_cnt[r_cls] - 1'b1;
                    r_gslot  <= r_fl_rd;
                    r_gclass <= r_cls;
                    r_state  <= S_OUT;
                end
                S_RET: begin
                    // Return the slot to the list of its recorded class.
                    if (r_cnt[r_rd_class] >= CB'(LIST_DEPTH)) begin
                        r_status <= ST_LIST_FULL;
                    end else begin
                        r_fl_mem[MB'(r_rd_class * LIST_DEPTH) + MB'(r_tail[r_rd_class])]
                            <= r_rd_slot;
                        r_tail[r_rd_class] <= (r_tail[r_rd_class] == LB'(LIST_DEPTH - 1)) ?
                                              '0 : r_tail[r_rd_class] + 1'b1;
                        r_cnt[r_rd_class] <= r_cnt[r_rd_class] + 1'b1;
                        r_valid[r_hit_idx] <= 1'b0;
                        r_gslot  <= r_rd_slot;
                        r_gclass <= r_rd_class;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- bench/size_class_best_fit_slot_allocator_unit_tb.sv -----
// Testbench for the size-class slot allocator: directed and random items checked by a scoreboard.
module size_class_best_fit_slot_allocator_unit_tb;
    import scba_pkg::*;

    localparam int LIST_DEPTH    = LIST_DEPTH_DEF;
    localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 1670;

    // Unused operation code; the block answers it with ST_OK and changes no state.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Shadow copy of the allocator state; predicts one result per accepted item.
    class alloc_scoreboard;
        logic [9:0]  list_slots[NUM_CLASSES][$];
        bit          ent_valid[TABLE_ENTRIES];
        logic [31:0] ent_key[TABLE_ENTRIES];
        logic [9:0]  ent_slot[TABLE_ENTRIES];
        logic [2:0]  ent_class[TABLE_ENTRIES];
        logic [15:0] pending[$];
        int          errors;

        function int find_key(logic [31:0] key);
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (ent_valid[i] && ent_key[i] == key) return i;
            end
            return -1;
        endfunction

        // Note an accepted item and queue the expected status, slot and class.
        function void note_item(logic [1:0] op, logic [2:0] cls, logic [9:0] slot,
                                logic [31:0] key);
            logic [2:0] st;
            logic [9:0] gs;
            logic [2:0] gc;
            int fit;
            int idx;
            st = ST_OK;
            gs = '0;
            gc = '0;
            if (op == OP_ADD) begin
                if (cls > XL || list_slots[cls].size() >= LIST_DEPTH) st = ST_LIST_FULL;
                else list_slots[cls].push_back(slot);
            end else if (op == OP_STORE) begin
                fit = -1;
                if (cls <= XL) begin
                    for (int c = cls; c <= XL; c++) begin
                        if (fit < 0 && list_slots[c].size() > 0) fit = c;
                    end
                end
                if (fit < 0) begin
                    st = ST_NO_FIT;
                end else begin
                    idx = find_key(key);
                    if (idx < 0) begin
                        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
                            if (!ent_valid[i]) idx = i;
                        end
                    end
                    if (idx < 0) begin
                        st = ST_TABLE_FULL;
                    end else begin
                        gs = list_slots[fit].pop_front();
                        gc = fit[2:0];
                        ent_valid[idx] = 1'b1;
                        ent_key[idx]   = key;
                        ent_slot[idx]  = gs;
                        ent_class[idx] = gc;
                    end
                end
            end else if (op == OP_RETRIEVE) begin
                idx = find_key(key);
                if (idx < 0) begin
                    st = ST_UNKNOWN;
                end else if (list_slots[ent_class[idx]].size() >= LIST_DEPTH) begin
                    st = ST_LIST_FULL;
                end else begin
                    list_slots[ent_class[idx]].push_back(ent_slot[idx]);
                    ent_valid[idx] = 1'b0;
                    gs = ent_slot[idx];
                    gc = ent_class[idx];
                end
            end
            pending.push_back({st, gs, gc});
        endfunction

        // Compare one strobed result against the oldest expectation.
        function void check_result(logic [2:0] st, logic [9:0] gs, logic [2:0] gc);
            logic [15:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status=%0d slot=%0d class=%0d",
                         $time, st, gs, gc);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want[15:13] !== st) begin
                $display("%0t: status expected %0d actual %0d", $time, want[15:13], st);
                errors++;
            end
            if (want[12:3] !== gs) begin
                $display("%0t: slot expected %0d actual %0d", $time, want[12:3], gs);
                errors++;
            end
            if (want[2:0] !== gc) begin
                $display("%0t: class expected %0d actual %0d", $time, want[2:0], gc);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_operation;
    logic [2:0]  i_size_class;
    logic [9:0]  i_slot_id;
    logic [31:0] i_item_key;
    logic        o_done;
    logic [2:0]  o_status;
    logic [9:0]  o_granted_slot;
    logic [2:0]  o_granted_class;

    alloc_scoreboard sb;
    int          cycles;
    bit          calm;
    logic [31:0] key_pool[16];

    size_class_best_fit_slot_allocator_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_size_class   (i_size_class),
        .i_slot_id      (i_slot_id),
        .i_item_key     (i_item_key),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_granted_slot (o_granted_slot),
        .o_granted_class(o_granted_class)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Results are sampled at the edge that ends their strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_status, o_granted_slot, o_granted_class);
    end

    // Cycle counter guards against a hung block.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Present one item, hold start while the block is busy, then drop start.
    task automatic send_item(logic [1:0] op, logic [2:0] cls, logic [9:0] slot,
                             logic [31:0] key);
        if (!calm && $urandom_range(99) < 16) begin
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_operation  <= op;
        i_size_class <= cls;
        i_slot_id    <= slot;
        i_item_key   <= key;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_item(op, cls, slot, key);
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random item, weighted toward keys that are likely present in the table.
    task automatic random_item();
        int r;
        logic [31:0] key;
        logic [2:0]  cls;
        r = $urandom_range(99);
        key = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(15)];
        cls = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        if (r < 35) send_item(OP_ADD, cls, 10'($urandom()), key);
        else if (r < 65) send_item(OP_STORE, cls, 10'($urandom()), key);
        else if (r < 97) send_item(OP_RETRIEVE, cls, 10'($urandom()), key);
        else send_item(OP_UNUSED, cls, 10'($urandom()), $urandom());
    endtask

    initial begin
        sb = new();
        calm = 1'b0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_operation <= '0;
        i_size_class <= '0;
        i_slot_id <= '0;
        i_item_key <= '0;
        for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty lists, out-of-range classes, extremes and the unused code.
        send_item(OP_STORE, 3'd0, 10'd0, 32'h0);
        send_item(OP_RETRIEVE, 3'd0, 10'd0, 32'h0);
        send_item(OP_ADD, 3'd7, 10'h3FF, 32'h0);
        send_item(OP_ADD, 3'd4, 10'h3FF, 32'hFFFF_FFFF);
        send_item(OP_ADD, 3'd0, 10'h000, 32'h0);
        send_item(OP_ADD, 3'd2, 10'h155, 32'h0);
        send_item(OP_STORE, 3'd5, 10'd0, 32'h0);
        send_item(OP_STORE, 3'd1, 10'd0, 32'hFFFF_FFFF);
        send_item(OP_STORE, 3'd0, 10'd0, 32'hFFFF_FFFF);
        send_item(OP_STORE, 3'd4, 10'd0, 32'h0);
        send_item(OP_RETRIEVE, 3'd0, 10'd0, 32'hFFFF_FFFF);
        send_item(OP_RETRIEVE, 3'd6, 10'd0, 32'h1234_5678);
        send_item(OP_UNUSED, 3'd7, 10'h3FF, 32'hFFFF_FFFF);

        // Directed: fill class 3 to capacity, overflow it, and fill the table.
        for (int i = 0; i <= LIST_DEPTH; i++) send_item(OP_ADD, 3'd3, 10'(i), 32'h0);
        for (int i = 0; i <= TABLE_ENTRIES; i++) send_item(OP_STORE, 3'd3, 10'd0, 32'(i + 100));
        send_item(OP_STORE, 3'd3, 10'd0, 32'd105);
        // Home list full on retrieve: refill class 3 then try to free into it.
        for (int i = 0; i < LIST_DEPTH; i++) send_item(OP_ADD, 3'd3, 10'(~i), 32'h0);
        send_item(OP_RETRIEVE, 3'd0, 10'd0, 32'd100);
        for (int i = 0; i < 8; i++) send_item(OP_STORE, 3'd0, 10'd0, 32'(i + 200));
        for (int i = 0; i < TABLE_ENTRIES; i++) send_item(OP_RETRIEVE, 3'd0, 10'd0, 32'(i + 100));

        // Random phase, with a stretch of back-to-back items in the middle.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 800 && n < 1100);
            if (n % 300 == 0) key_pool[$urandom_range(15, 2)] = $urandom();
            random_item();
        end

        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
